// ----- src/ssa_pkg.sv -----
// ssa_pkg: shared types and constants of the swap slot allocator
// no dependencies; used by the front, back and top level
`default_nettype none

package ssa_pkg;

    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_DUP   = 3'd1;
    localparam logic [2:0] OP_FREE  = 3'd2;
    localparam logic [2:0] OP_LOAD  = 3'd3;
    localparam logic [2:0] OP_MODE  = 3'd4;

    localparam logic [7:0] RESERVED_COUNT = 8'd128;
    localparam logic [7:0] COUNT_MAX      = 8'hFF;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_NO_FREE     = 4'd1,
        ST_BAD_DEVICE  = 4'd2,
        ST_BAD_SLOT    = 4'd3,
        ST_DEV_UNUSED  = 4'd4,
        ST_SLOT_UNUSED = 4'd5,
        ST_COUNT_ZERO  = 4'd6,
        ST_NULL        = 4'd7,
        ST_SATURATED   = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_DRAIN    = 2'd1,
        MODE_WRITABLE = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        K_ALLOC = 3'd0,
        K_DUP   = 3'd1,
        K_FREE  = 3'd2,
        K_LOAD  = 3'd3,
        K_MODE  = 3'd4,
        K_REPLY = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_EXEC     = 3'd1,
        S_RMW      = 3'd2,
        S_DEV      = 3'd3,
        S_SCAN_RD  = 3'd4,
        S_SCAN_CHK = 3'd5
    } t_state;

    typedef struct packed {
        t_kind      kind;
        t_status    status;
        logic [2:0] device;
        logic       reserved;
        t_mode      mode;
        logic       clear_hints;
    } t_cmd;

endpackage

`default_nettype wire

// ----- src/ssa_ram.sv -----
// ssa_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/ssa_fifo.sv -----
// ssa_fifo: short request queue between the front and back parts
// no dependencies
`default_nettype none

module ssa_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/ssa_front.sv -----
// ssa_front: takes requests and classifies them, screening handle and range errors
// depends on ssa_pkg
`default_nettype none

module ssa_front #(
    parameter int DEVICES = 8,
    parameter int SLOTS   = 4096
) (
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [2:0]               i_opcode,
    input  wire logic [2:0]               i_device,
    input  wire logic [23:0]              i_slot,
    input  wire logic                     i_slot_reserved,
    input  wire logic [1:0]               i_mode,
    input  wire logic                     i_clear_hints,
    input  wire logic [3:0]               i_limit,
    input  wire logic                     i_full,
    output logic                          o_push,
    output ssa_pkg::t_cmd                 o_cmd,
    output logic      [$clog2(SLOTS)-1:0] o_slot
);

    localparam int SW = $clog2(SLOTS);
    localparam logic [3:0]  DEV_LIMIT  = 4'(DEVICES);
    localparam logic [23:0] SLOT_LIMIT = 24'(SLOTS);

    logic is_null;
    logic dev_bad;
    logic dev_inactive;
    logic slot_bad;

    assign o_stall      = i_full;
    assign o_push       = i_valid && !i_full;
    assign o_slot       = SW'(i_slot);
    assign is_null      = (i_device == 3'd0) && (i_slot == 24'd0);
    assign dev_bad      = ({1'b0, i_device} >= DEV_LIMIT);
    assign dev_inactive = ({1'b0, i_device} >= i_limit);
    assign slot_bad     = (i_slot >= SLOT_LIMIT);

    always_comb begin
        o_cmd.kind        = ssa_pkg::K_REPLY;
        o_cmd.status      = ssa_pkg::ST_NULL;
        o_cmd.device      = i_device;
        o_cmd.reserved    = i_slot_reserved;
        o_cmd.mode        = (i_mode > 2'(ssa_pkg::MODE_WRITABLE)) ? ssa_pkg::MODE_OFF
                                                                  : ssa_pkg::t_mode'(i_mode);
        o_cmd.clear_hints = i_clear_hints;
        unique case (i_opcode) inside
            ssa_pkg::OP_ALLOC: begin
                o_cmd.kind = ssa_pkg::K_ALLOC;
            end
            ssa_pkg::OP_DUP, ssa_pkg::OP_FREE: begin
                if (is_null) begin
                    o_cmd.status = ssa_pkg::ST_NULL;
                end else if (dev_inactive) begin
                    o_cmd.status = ssa_pkg::ST_BAD_DEVICE;
                end else if (slot_bad) begin
                    o_cmd.status = ssa_pkg::ST_BAD_SLOT;
                end else begin
                    o_cmd.kind = (i_opcode == ssa_pkg::OP_DUP) ? ssa_pkg::K_DUP
                                                               : ssa_pkg::K_FREE;
                end
            end
            ssa_pkg::OP_LOAD: begin
                if (dev_bad) begin
                    o_cmd.status = ssa_pkg::ST_BAD_DEVICE;
                end else if (slot_bad) begin
                    o_cmd.status = ssa_pkg::ST_BAD_SLOT;
                end else begin
                    o_cmd.kind = ssa_pkg::K_LOAD;
                end
            end
            ssa_pkg::OP_MODE: begin
                if (dev_bad) begin
                    o_cmd.status = ssa_pkg::ST_BAD_DEVICE;
                end else begin
                    o_cmd.kind = ssa_pkg::K_MODE;
                end
            end
            default: begin
                o_cmd.status = ssa_pkg::ST_NULL;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/ssa_back.sv -----
// ssa_back: executes classified requests against the slot count ram and device table
// depends on ssa_pkg and ssa_ram
`default_nettype none

module ssa_back #(
    parameter int DEVICES = 8,
    parameter int SLOTS   = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [3:0]               i_limit,
    input  wire logic                     i_cmd_valid,
    input  wire ssa_pkg::t_cmd            i_cmd,
    input  wire logic [$clog2(SLOTS)-1:0] i_slot,
    output logic                          o_pop,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic      [3:0]               o_status,
    output logic      [2:0]               o_out_device,
    output logic      [11:0]              o_out_slot,
    output logic      [7:0]               o_new_count
);

    localparam int SW = $clog2(SLOTS);
    localparam int BW = $clog2(SLOTS + 1);
    localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int DEPTH = DEVICES * SLOTS;
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] SLOTS_A = AW'(SLOTS);
    localparam logic [BW-1:0] SLOTS_B = BW'(SLOTS);

    ssa_pkg::t_state  r_state, n_state;
    ssa_pkg::t_cmd    r_cmd, n_cmd;
    logic [3:0]       r_dev, n_dev;
    logic [BW-1:0]    r_b, n_b;
    ssa_pkg::t_mode   r_mode [DEVICES];
    ssa_pkg::t_mode   n_mode [DEVICES];
    logic [SW-1:0]    r_low  [DEVICES];
    logic [SW-1:0]    n_low  [DEVICES];
    logic [SW-1:0]    r_high [DEVICES];
    logic [SW-1:0]    n_high [DEVICES];

    logic             r_out_valid, n_out_valid;
    ssa_pkg::t_status r_status, n_status;
    logic [2:0]       r_out_device, n_out_device;
    logic [11:0]      r_out_slot, n_out_slot;
    logic [7:0]       r_new_count, n_new_count;

    logic             out_free;
    logic [DW-1:0]    idx;
    logic [SW-1:0]    slot_h;
    ssa_pkg::t_mode   cur_mode;
    logic [SW-1:0]    cur_low;
    logic [SW-1:0]    cur_high;
    logic [AW-1:0]    ram_addr;
    logic             ram_we;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;

    logic             fin;
    ssa_pkg::t_status fin_status;
    logic [2:0]       fin_dev;
    logic [11:0]      fin_slot;
    logic [7:0]       fin_count;

    assign out_free = !r_out_valid || !i_stall;
    assign idx      = r_dev[DW-1:0];
    assign slot_h   = r_b[SW-1:0];
    assign cur_mode = r_mode[idx];
    assign cur_low  = r_low[idx];
    assign cur_high = r_high[idx];
    assign ram_addr = AW'(idx) * SLOTS_A + AW'(slot_h);

    ssa_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_dev        = r_dev;
        n_b          = r_b;
        n_mode       = r_mode;
        n_low        = r_low;
        n_high       = r_high;
        n_out_valid  = r_out_valid && i_stall;
        n_status     = r_status;
        n_out_device = r_out_device;
        n_out_slot   = r_out_slot;
        n_new_count  = r_new_count;
        o_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_wdata    = '0;
        fin          = 1'b0;
        fin_status   = ssa_pkg::ST_OK;
        fin_dev      = '0;
        fin_slot     = '0;
        fin_count    = '0;

        unique case (r_state)
            ssa_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_dev   = {1'b0, i_cmd.device};
                    n_b     = BW'(i_slot);
                    n_state = ssa_pkg::S_EXEC;
                end
            end
            ssa_pkg::S_EXEC: begin
                unique case (r_cmd.kind)
                    ssa_pkg::K_ALLOC: begin
                        n_dev   = '0;
                        n_state = ssa_pkg::S_DEV;
                    end
                    ssa_pkg::K_DUP: begin
                        n_state = ssa_pkg::S_RMW;
                    end
                    ssa_pkg::K_FREE: begin
                        if (cur_mode == ssa_pkg::MODE_OFF) begin
                            if (out_free) begin
                                fin        = 1'b1;
                                fin_status = ssa_pkg::ST_DEV_UNUSED;
                            end
                        end else begin
                            if (slot_h < cur_low) begin
                                n_low[idx] = slot_h;
                            end
                            if (slot_h > cur_high) begin
                                n_high[idx] = slot_h;
                            end
                            n_state = ssa_pkg::S_RMW;
                        end
                    end
                    ssa_pkg::K_LOAD: begin
                        if (out_free) begin
                            ram_we    = 1'b1;
                            ram_wdata = r_cmd.reserved ? ssa_pkg::RESERVED_COUNT : 8'd0;
                            if (!r_cmd.reserved) begin
                                if (cur_low == '0 || cur_low > slot_h) begin
                                    n_low[idx] = slot_h;
                                end
                                if (cur_high < slot_h) begin
                                    n_high[idx] = slot_h;
                                end
                            end
                            fin       = 1'b1;
                            fin_dev   = r_dev[2:0];
                            fin_slot  = 12'(slot_h);
                            fin_count = ram_wdata;
                        end
                    end
                    ssa_pkg::K_MODE: begin
                        if (out_free) begin
                            n_mode[idx] = r_cmd.mode;
                            if (r_cmd.clear_hints) begin
                                n_low[idx]  = '0;
                                n_high[idx] = '0;
                            end
                            fin     = 1'b1;
                            fin_dev = r_dev[2:0];
                        end
                    end
                    ssa_pkg::K_REPLY: begin
                        if (out_free) begin
                            fin        = 1'b1;
                            fin_status = r_cmd.status;
                        end
                    end
                    default: begin
                        n_state = ssa_pkg::S_IDLE;
                    end
                endcase
            end
            ssa_pkg::S_RMW: begin
                if (out_free) begin
                    fin = 1'b1;
                    if (ram_rdata == 8'd0) begin
                        fin_status = ssa_pkg::ST_COUNT_ZERO;
                    end else if (r_cmd.kind == ssa_pkg::K_DUP
                                 && ram_rdata == ssa_pkg::COUNT_MAX) begin
                        fin_status = ssa_pkg::ST_SATURATED;
                        fin_dev    = r_dev[2:0];
                        fin_slot   = 12'(slot_h);
                        fin_count  = ssa_pkg::COUNT_MAX;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = (r_cmd.kind == ssa_pkg::K_DUP) ? ram_rdata + 8'd1
                                                                   : ram_rdata - 8'd1;
                        fin_dev   = r_dev[2:0];
                        fin_slot  = 12'(slot_h);
                        fin_count = ram_wdata;
                    end
                end
            end
            ssa_pkg::S_DEV: begin
                if (r_dev >= i_limit) begin
                    if (out_free) begin
                        fin        = 1'b1;
                        fin_status = ssa_pkg::ST_NO_FREE;
                    end
                end else if (cur_mode != ssa_pkg::MODE_WRITABLE) begin
                    n_dev = r_dev + 4'd1;
                end else begin
                    n_b     = BW'(cur_low);
                    n_state = ssa_pkg::S_SCAN_RD;
                end
            end
            ssa_pkg::S_SCAN_RD: begin
                if (r_b > BW'(cur_high) || r_b >= SLOTS_B) begin
                    n_dev   = r_dev + 4'd1;
                    n_state = ssa_pkg::S_DEV;
                end else begin
                    n_state = ssa_pkg::S_SCAN_CHK;
                end
            end
            ssa_pkg::S_SCAN_CHK: begin
                if (ram_rdata == 8'd0) begin
                    if (out_free) begin
                        ram_we    = 1'b1;
                        ram_wdata = 8'd1;
                        if (slot_h == cur_high && cur_high != '0) begin
                            n_high[idx] = cur_high - SW'(1);
                        end
                        n_low[idx] = slot_h;
                        fin        = 1'b1;
                        fin_dev    = r_dev[2:0];
                        fin_slot   = 12'(slot_h);
                        fin_count  = 8'd1;
                    end
                end else begin
                    n_b     = r_b + BW'(1);
                    n_state = ssa_pkg::S_SCAN_RD;
                end
            end
            default: begin
                n_state = ssa_pkg::S_IDLE;
            end
        endcase

        if (fin) begin
            n_state      = ssa_pkg::S_IDLE;
            n_out_valid  = 1'b1;
            n_status     = fin_status;
            n_out_device = fin_dev;
            n_out_slot   = fin_slot;
            n_new_count  = fin_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < DEVICES; i++) begin
                r_mode[i] <= ssa_pkg::MODE_OFF;
                r_low[i]  <= '0;
                r_high[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_mode      <= n_mode;
            r_low       <= n_low;
            r_high      <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_dev        <= n_dev;
        r_b          <= n_b;
        r_status     <= n_status;
        r_out_device <= n_out_device;
        r_out_slot   <= n_out_slot;
        r_new_count  <= n_new_count;
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_out_device = r_out_device;
    assign o_out_slot   = r_out_slot;
    assign o_new_count  = r_new_count;

`ifndef SYNTHESIS
    a_write_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_out_valid)
        else $error("count write without a result");

    a_fail_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ssa_pkg::ST_OK && r_status != ssa_pkg::ST_SATURATED)
        |-> (r_out_device == '0 && r_out_slot == '0 && r_new_count == '0))
        else $error("failed request reports a slot");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssa_pkg::S_SCAN_CHK) |-> (r_b < SLOTS_B))
        else $error("scan beyond last slot");

    a_dev_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssa_pkg::S_DEV) |-> (r_dev <= i_limit))
        else $error("device walk past active devices");
`endif

endmodule

`default_nettype wire

// ----- src/swap_slot_allocator.sv -----
// swap_slot_allocator: top level, config register, front, request queue and back
// depends on ssa_pkg, ssa_front, ssa_fifo, ssa_back
`default_nettype none

// Reference-counted swap slot allocator. Requests are taken one per cycle, while the
// two-entry queue has room, and executed one at a time by the back end against a slot
// count ram of DEVICES*SLOTS bytes (one read and one write port, registered read), so
// the ram port and the back-end sequencer set the rate. Screened errors, set-mode, load
// and free on an unused device finish without a read; duplicate and free read the count,
// then modify-write it. Allocate visits the devices in turn and examines the slots
// between each writable device's hints, until a free slot is found or none is left.
// A finished result waits in an output register while the next request starts.
// Slot counts have no reset and no clearing pass: load every slot before it is used.
// active_devices is written over the apb port at addresses 0 to 3 (paddr[2] low). The
// user must write it only while the block is idle; the block does not enforce this.
module swap_slot_allocator #(
    parameter int DEVICES = 8,
    parameter int SLOTS   = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [2:0]  i_device,
    input  wire logic [23:0] i_slot,
    input  wire logic        i_slot_reserved,
    input  wire logic [1:0]  i_mode,
    input  wire logic        i_clear_hints,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [3:0]  o_status,
    output logic      [2:0]  o_out_device,
    output logic      [11:0] o_out_slot,
    output logic      [7:0]  o_new_count
);

    localparam int SW = $clog2(SLOTS);
    localparam int QW = $bits(ssa_pkg::t_cmd) + SW;
    localparam logic [3:0] DEV_LIMIT = 4'(DEVICES);

    logic [3:0]    r_active_devices;
    logic [3:0]    limit;
    logic          cfg_wr;

    logic          f_push;
    ssa_pkg::t_cmd f_cmd;
    logic [SW-1:0] f_slot;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_data;
    ssa_pkg::t_cmd q_cmd;
    logic [SW-1:0] q_slot;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {28'd0, r_active_devices};
    assign limit  = (r_active_devices > DEV_LIMIT) ? DEV_LIMIT : r_active_devices;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_devices <= '0;
        end else if (cfg_wr) begin
            r_active_devices <= pwdata[3:0];
        end
    end

    ssa_front #(
        .DEVICES (DEVICES),
        .SLOTS   (SLOTS)
    ) u_front (
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_device        (i_device),
        .i_slot          (i_slot),
        .i_slot_reserved (i_slot_reserved),
        .i_mode          (i_mode),
        .i_clear_hints   (i_clear_hints),
        .i_limit         (limit),
        .i_full          (q_full),
        .o_push          (f_push),
        .o_cmd           (f_cmd),
        .o_slot          (f_slot)
    );

    ssa_fifo #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_cmd, f_slot}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign {q_cmd, q_slot} = q_data;

    ssa_back #(
        .DEVICES (DEVICES),
        .SLOTS   (SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_limit      (limit),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .i_slot       (q_slot),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_out_device (o_out_device),
        .o_out_slot   (o_out_slot),
        .o_new_count  (o_new_count)
    );

endmodule

`default_nettype wire

// ----- test/swap_slot_allocator_tb.sv -----
// swap_slot_allocator_tb: self-checking testbench for the swap slot allocator
// drives requests and the apb register, predicts every result and compares it
// depends on ssa_pkg and swap_slot_allocator
`timescale 1ns / 1ps

module swap_slot_allocator_tb;

    localparam int NDEV           = 8;
    localparam int NSLOT          = 4096;
    localparam int POOL           = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [2:0] ADDR_ACTIVE_DEVICES = 3'd0;

    typedef struct packed {
        ssa_pkg::t_status status;
        logic [2:0]       device;
        logic [11:0]      slot;
        logic [7:0]       count;
    } t_slot_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_opcode;
    logic [2:0]  i_device;
    logic [23:0] i_slot;
    logic        i_slot_reserved;
    logic [1:0]  i_mode;
    logic        i_clear_hints;
    logic        o_valid;
    logic        i_stall;
    logic [3:0]  o_status;
    logic [2:0]  o_out_device;
    logic [11:0] o_out_slot;
    logic [7:0]  o_new_count;

    // predicted block state
    logic [7:0]     slot_count  [NDEV][NSLOT];
    bit             slot_loaded [NDEV][NSLOT];
    ssa_pkg::t_mode dev_mode    [NDEV] = '{default: ssa_pkg::MODE_OFF};
    int             lo_hint     [NDEV];
    int             hi_hint     [NDEV];
    logic [3:0]     active_cfg;

    t_slot_outcome outcome_q [$];
    int            mismatches;
    bit            gaps_on;
    bit            hold_out;
    int            stall_left;
    int            quiet_cycles;

    swap_slot_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_device        (i_device),
        .i_slot          (i_slot),
        .i_slot_reserved (i_slot_reserved),
        .i_mode          (i_mode),
        .i_clear_hints   (i_clear_hints),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_out_device    (o_out_device),
        .o_out_slot      (o_out_slot),
        .o_new_count     (o_new_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int device_limit();
        return (int'(active_cfg) > NDEV) ? NDEV : int'(active_cfg);
    endfunction

    // updates the predicted state and returns the result of one request
    function automatic t_slot_outcome apply_request(input logic [2:0] op, input logic [2:0] dev,
                                                    input logic [23:0] slot, input logic rsv,
                                                    input logic [1:0] mode, input logic clr);
        t_slot_outcome r;
        int lim;
        int d;
        int b;
        bit found;
        logic [11:0] s;
        r = '{ssa_pkg::ST_OK, 3'd0, 12'd0, 8'd0};
        lim = device_limit();
        s = slot[11:0];
        found = 1'b0;
        case (op)
            ssa_pkg::OP_ALLOC: begin
                for (d = 0; d < lim; d++) begin
                    if (!found && dev_mode[d] == ssa_pkg::MODE_WRITABLE) begin
                        for (b = lo_hint[d]; !found && b <= hi_hint[d] && b < NSLOT; b++) begin
                            if (slot_count[d][b] == 8'd0) begin
                                found = 1'b1;
                                slot_count[d][b] = 8'd1;
                                slot_loaded[d][b] = 1'b1;
                                if (b == hi_hint[d] && hi_hint[d] > 0)
                                    hi_hint[d] = hi_hint[d] - 1;
                                lo_hint[d] = b;
                                r = '{ssa_pkg::ST_OK, 3'(d), 12'(b), 8'd1};
                            end
                        end
                    end
                end
                if (!found)
                    r.status = ssa_pkg::ST_NO_FREE;
            end
            ssa_pkg::OP_DUP, ssa_pkg::OP_FREE: begin
                if (dev == 3'd0 && slot == 24'd0)
                    r.status = ssa_pkg::ST_NULL;
                else if (int'(dev) >= lim)
                    r.status = ssa_pkg::ST_BAD_DEVICE;
                else if (slot >= NSLOT)
                    r.status = ssa_pkg::ST_BAD_SLOT;
                else if (op == ssa_pkg::OP_DUP) begin
                    if (slot_count[dev][s] == 8'd0)
                        r.status = ssa_pkg::ST_COUNT_ZERO;
                    else if (slot_count[dev][s] == ssa_pkg::COUNT_MAX)
                        r = '{ssa_pkg::ST_SATURATED, dev, s, ssa_pkg::COUNT_MAX};
                    else begin
                        slot_count[dev][s] = slot_count[dev][s] + 8'd1;
                        r = '{ssa_pkg::ST_OK, dev, s, slot_count[dev][s]};
                    end
                end else if (dev_mode[dev] == ssa_pkg::MODE_OFF)
                    r.status = ssa_pkg::ST_DEV_UNUSED;
                else begin
                    if (int'(slot) < lo_hint[dev])
                        lo_hint[dev] = int'(slot);
                    if (int'(slot) > hi_hint[dev])
                        hi_hint[dev] = int'(slot);
                    if (slot_count[dev][s] == 8'd0)
                        r.status = ssa_pkg::ST_COUNT_ZERO;
                    else begin
                        slot_count[dev][s] = slot_count[dev][s] - 8'd1;
                        r = '{ssa_pkg::ST_OK, dev, s, slot_count[dev][s]};
                    end
                end
            end
            ssa_pkg::OP_LOAD: begin
                if (int'(dev) >= NDEV)
                    r.status = ssa_pkg::ST_BAD_DEVICE;
                else if (slot >= NSLOT)
                    r.status = ssa_pkg::ST_BAD_SLOT;
                else begin
                    slot_count[dev][s] = rsv ? ssa_pkg::RESERVED_COUNT : 8'd0;
                    slot_loaded[dev][s] = 1'b1;
                    if (!rsv) begin
                        if (lo_hint[dev] == 0 || lo_hint[dev] > int'(slot))
                            lo_hint[dev] = int'(slot);
                        if (hi_hint[dev] < int'(slot))
                            hi_hint[dev] = int'(slot);
                    end
                    r = '{ssa_pkg::ST_OK, dev, s, slot_count[dev][s]};
                end
            end
            ssa_pkg::OP_MODE: begin
                if (int'(dev) >= NDEV)
                    r.status = ssa_pkg::ST_BAD_DEVICE;
                else begin
                    dev_mode[dev] = (mode > ssa_pkg::MODE_WRITABLE) ? ssa_pkg::MODE_OFF
                                                                    : ssa_pkg::t_mode'(mode);
                    if (clr) begin
                        lo_hint[dev] = 0;
                        hi_hint[dev] = 0;
                    end
                    r = '{ssa_pkg::ST_OK, dev, 12'd0, 8'd0};
                end
            end
            default: r.status = ssa_pkg::ST_NULL;
        endcase
        return r;
    endfunction

    // first device whose allocate scan would read a never-loaded count, or -1
    function automatic int alloc_scan_hazard();
        int lim;
        int d;
        int b;
        lim = device_limit();
        for (d = 0; d < lim; d++) begin
            if (dev_mode[d] == ssa_pkg::MODE_WRITABLE) begin
                for (b = lo_hint[d]; b <= hi_hint[d] && b < NSLOT; b++) begin
                    if (!slot_loaded[d][b])
                        return d;
                    if (slot_count[d][b] == 8'd0)
                        return -1;
                end
            end
        end
        return -1;
    endfunction

    function automatic bit reads_unloaded(input logic [2:0] op, input logic [2:0] dev,
                                          input logic [23:0] slot);
        if (op != ssa_pkg::OP_DUP && op != ssa_pkg::OP_FREE)
            return 1'b0;
        if ((dev == 3'd0 && slot == 24'd0) || int'(dev) >= device_limit() || slot >= NSLOT)
            return 1'b0;
        if (op == ssa_pkg::OP_FREE && dev_mode[dev] == ssa_pkg::MODE_OFF)
            return 1'b0;
        return !slot_loaded[dev][slot[11:0]];
    endfunction

    task automatic send_req(input logic [2:0] op, input logic [2:0] dev, input logic [23:0] slot,
                            input logic rsv, input logic [1:0] mode, input logic clr);
        int gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_opcode        <= op;
        i_device        <= dev;
        i_slot          <= slot;
        i_slot_reserved <= rsv;
        i_mode          <= mode;
        i_clear_hints   <= clr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        outcome_q.push_back(apply_request(op, dev, slot, rsv, mode, clr));
    endtask

    task automatic write_active_devices(input logic [3:0] val);
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_ACTIVE_DEVICES;
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        active_cfg = val;
        @(posedge i_clk);
    endtask

    task automatic send_random_request();
        int pick;
        int hz;
        logic [2:0]  op;
        logic [2:0]  dev;
        logic [23:0] slot;
        logic        rsv;
        logic [1:0]  mode;
        logic        clr;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            op = ssa_pkg::OP_ALLOC;
        else if (pick < 45)
            op = ssa_pkg::OP_DUP;
        else if (pick < 70)
            op = ssa_pkg::OP_FREE;
        else if (pick < 82)
            op = ssa_pkg::OP_LOAD;
        else if (pick < 94)
            op = ssa_pkg::OP_MODE;
        else
            op = 3'($urandom_range(5, 7));
        dev = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 85)
            slot = 24'($urandom_range(0, POOL - 1));
        else if (pick < 90)
            slot = 24'(NSLOT - 1);
        else
            slot = 24'($urandom);
        rsv  = ($urandom_range(0, 4) == 0);
        mode = ($urandom_range(0, 9) < 6) ? ssa_pkg::MODE_WRITABLE
                                          : 2'($urandom_range(0, 3));
        clr  = ($urandom_range(0, 3) == 0);
        if (op == ssa_pkg::OP_ALLOC) begin
            // pull the hints of a device back to slot zero before its scan runs into
            // slots that were never loaded
            hz = alloc_scan_hazard();
            while (hz >= 0) begin
                send_req(ssa_pkg::OP_MODE, 3'(hz), 24'($urandom), 1'($urandom), dev_mode[hz],
                         1'b1);
                hz = alloc_scan_hazard();
            end
        end else if (reads_unloaded(op, dev, slot))
            op = ssa_pkg::OP_LOAD;
        send_req(op, dev, slot, rsv, mode, clr);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // result checker and receiver stall
    always @(posedge i_clk) begin
        t_slot_outcome want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: result with no request pending: status %0d device %0d slot %0d",
                         $time, o_status, o_out_device, o_out_slot);
                mismatches++;
            end else begin
                want = outcome_q.pop_front();
                check_field("status", want.status, o_status);
                check_field("out_device", want.device, o_out_device);
                check_field("out_slot", want.slot, o_out_slot);
                check_field("new_count", want.count, o_new_count);
            end
            stall_left = gaps_on ? $urandom_range(0, 9) : 0;
        end
        if (hold_out)
            i_stall <= 1'b1;
        else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else
            i_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // errors caught before any slot count is read
    task automatic test_screened_errors();
        send_req(ssa_pkg::OP_ALLOC, 3'd0, 24'd0, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_DUP, 3'd0, 24'd0, 1'b1, ssa_pkg::MODE_WRITABLE, 1'b1);
        send_req(ssa_pkg::OP_FREE, 3'd0, 24'd0, 1'b0, 2'd3, 1'b0);
        send_req(ssa_pkg::OP_DUP, 3'd5, 24'hFFFFFF, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_FREE, 3'd7, 24'h001000, 1'b1, ssa_pkg::MODE_DRAIN, 1'b1);
        send_req(ssa_pkg::OP_FREE, 3'd2, 24'd3, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_LOAD, 3'd7, 24'h800000, 1'b1, ssa_pkg::MODE_OFF, 1'b0);
        send_req(3'd5, 3'd7, 24'hFFFFFF, 1'b1, 2'd3, 1'b1);
        send_req(3'd6, 3'd1, 24'd1, 1'b0, ssa_pkg::MODE_DRAIN, 1'b0);
        send_req(3'd7, 3'd0, 24'd0, 1'b1, ssa_pkg::MODE_WRITABLE, 1'b1);
        send_req(ssa_pkg::OP_MODE, 3'd3, 24'hABCDEF, 1'b1, 2'd3, 1'b1);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_load_pool();
        int d;
        int s;
        for (d = 0; d < NDEV; d++)
            for (s = 0; s < POOL; s++)
                send_req(ssa_pkg::OP_LOAD, 3'(d), 24'(s), 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_LOAD, 3'd7, 24'(NSLOT - 1), 1'b1, ssa_pkg::MODE_WRITABLE, 1'b1);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_slot_ops();
        send_req(ssa_pkg::OP_MODE, 3'd0, 24'd0, 1'b0, ssa_pkg::MODE_WRITABLE, 1'b1);
        send_req(ssa_pkg::OP_ALLOC, 3'd0, 24'd0, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_ALLOC, 3'd0, 24'd0, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_DUP, 3'd1, 24'd2, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_FREE, 3'd0, 24'd5, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_ALLOC, 3'd0, 24'd0, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_DUP, 3'd0, 24'd1, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_FREE, 3'd0, 24'd1, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_FREE, 3'd0, 24'd1, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_MODE, 3'd6, 24'd0, 1'b0, ssa_pkg::MODE_WRITABLE, 1'b0);
        send_req(ssa_pkg::OP_ALLOC, 3'd0, 24'd0, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_MODE, 3'd0, 24'd0, 1'b0, ssa_pkg::MODE_DRAIN, 1'b0);
        send_req(ssa_pkg::OP_ALLOC, 3'd0, 24'd0, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        // claim the slot sitting at the high hint
        send_req(ssa_pkg::OP_MODE, 3'd6, 24'd0, 1'b0, ssa_pkg::MODE_WRITABLE, 1'b1);
        send_req(ssa_pkg::OP_LOAD, 3'd6, 24'd3, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_ALLOC, 3'd0, 24'd0, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_ALLOC, 3'd0, 24'd0, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_FREE, 3'd6, 24'd3, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_saturation();
        int k;
        send_req(ssa_pkg::OP_LOAD, 3'd2, 24'd9, 1'b1, ssa_pkg::MODE_OFF, 1'b0);
        for (k = 0; k < 128; k++)
            send_req(ssa_pkg::OP_DUP, 3'd2, 24'd9, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_FREE, 3'd2, 24'd9, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        send_req(ssa_pkg::OP_LOAD, 3'd2, 24'd9, 1'b0, ssa_pkg::MODE_OFF, 1'b0);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_random_phase(input logic [3:0] devices, input int n);
        int i;
        write_active_devices(devices);
        gaps_on = ($urandom_range(0, 2) != 0);
        for (i = 0; i < n; i++)
            send_random_request();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver holds off while requests keep coming until the input stalls
    task automatic test_backpressure();
        int i;
        gaps_on = 1'b0;
        fork
            begin
                hold_out = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out = 1'b0;
            end
        join_none
        for (i = 0; i < 60; i++)
            send_random_request();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= 3'd0;
        pwdata          <= 32'd0;
        i_valid         <= 1'b0;
        i_opcode        <= ssa_pkg::OP_ALLOC;
        i_device        <= 3'd0;
        i_slot          <= 24'd0;
        i_slot_reserved <= 1'b0;
        i_mode          <= ssa_pkg::MODE_OFF;
        i_clear_hints   <= 1'b0;
        i_stall         <= 1'b0;
        active_cfg   = 4'd0;
        mismatches   = 0;
        gaps_on      = 1'b1;
        hold_out     = 1'b0;
        stall_left   = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_active_devices(4'd8);
        test_screened_errors();
        gaps_on = 1'b0;
        test_load_pool();
        gaps_on = 1'b1;
        test_slot_ops();
        test_saturation();
        test_random_phase(4'd8, 100);
        test_random_phase(4'd3, 100);
        test_random_phase(4'd0, 40);
        test_random_phase(4'd1, 80);
        test_random_phase(4'd15, 100);
        test_random_phase(4'd5, 100);
        test_backpressure();

        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
